// ----- rtl/dwe_pkg.sv -----
// shared types and constants for the deque with erase by value
// command and status codes, field widths, controller/datapath interface structs
// no dependencies
`default_nettype none

package dwe_pkg;

  // default sizing of the store
  localparam int DEF_CAPACITY   = 16;
  localparam int DEF_DATA_WIDTH = 32;

  // fixed field widths on the ports
  localparam int CMD_W    = 3;
  localparam int ITEM_W   = 32;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 5;

  // command codes carried on in_tuser
  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH_BACK  = 3'd0,
    CMD_POP_BACK   = 3'd1,
    CMD_PUSH_FRONT = 3'd2,
    CMD_POP_FRONT  = 3'd3,
    CMD_ERASE      = 3'd4
  } cmd_t;

  // result status codes carried on out_tuser
  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_FULL      = 2'd3
  } status_t;

  // controller to datapath commands
  typedef struct packed {
    logic    push_back;   // write item behind the last entry
    logic    push_front;  // write item ahead of the front entry
    logic    pop_back;    // read last entry, drop it
    logic    pop_front;   // read front entry, drop it
    logic    scan_start;  // latch search key, read front entry
    logic    scan_step;   // advance scan pointer, read next entry
    logic    shift_wr;    // copy current entry one place toward the front
    logic    erase_done;  // drop one entry after a successful erase
    logic    load_out;    // load the result register
    logic    out_sel_rd;  // result value comes from the read data
    status_t out_status;  // status for the result register
  } dwe_ctrl_t;

  // datapath to controller status
  typedef struct packed {
    logic empty;  // no entries stored
    logic full;   // store holds capacity entries
    logic match;  // current read data equals the search key
    logic last;   // current read data is the last stored entry
  } dwe_stat_t;

endpackage

`default_nettype wire

// ----- rtl/dwe_datapath.sv -----
// datapath of the deque: ring store memory, front pointer, entry count,
// scan pointers for erase and the result register
// depends on dwe_pkg
`default_nettype none

module dwe_datapath #(
  parameter int CAPACITY   = dwe_pkg::DEF_CAPACITY,
  parameter int DATA_WIDTH = dwe_pkg::DEF_DATA_WIDTH
) (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire  [dwe_pkg::ITEM_W-1:0]   item_value,
  input  wire  dwe_pkg::dwe_ctrl_t     ctrl,
  output dwe_pkg::dwe_stat_t           stat,
  output logic [dwe_pkg::ITEM_W-1:0]   out_value,
  output logic [dwe_pkg::STATUS_W-1:0] out_status,
  output logic [dwe_pkg::COUNT_W-1:0]  out_count
);
  import dwe_pkg::*;

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int SW = CW + 1;
  localparam int IW = (DATA_WIDTH < ITEM_W) ? DATA_WIDTH : ITEM_W;

  logic [DATA_WIDTH-1:0] mem [CAPACITY];

  logic [AW-1:0]         front_r, front_nxt;
  logic [CW-1:0]         count_r, count_nxt;
  logic [AW-1:0]         rd_ptr_r, rd_ptr_nxt;
  logic [AW-1:0]         wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]         idx_r, idx_nxt;
  logic [DATA_WIDTH-1:0] key_r, key_nxt;
  logic [DATA_WIDTH-1:0] rd_data_r;
  logic [ITEM_W-1:0]     out_value_r;
  logic [STATUS_W-1:0]   out_status_r;
  logic [COUNT_W-1:0]    out_count_r;

  logic [DATA_WIDTH-1:0] item_d;
  logic [SW-1:0]         tail_sum, last_sum;
  logic [AW-1:0]         tail_addr, last_addr;
  logic [AW-1:0]         front_inc, front_dec, rd_ptr_inc;
  logic                  wr_en, rd_en;
  logic [AW-1:0]         wr_addr, rd_addr;
  logic [DATA_WIDTH-1:0] wr_data;

  // item value fitted to the stored word width
  assign item_d = DATA_WIDTH'(item_value[IW-1:0]);

  // ring positions: one past the last entry, and the last entry
  always_comb begin
    tail_sum  = SW'(front_r) + SW'(count_r);
    last_sum  = tail_sum - SW'(1);
    tail_addr = (tail_sum >= SW'(CAPACITY)) ? AW'(tail_sum - SW'(CAPACITY)) : AW'(tail_sum);
    last_addr = (last_sum >= SW'(CAPACITY)) ? AW'(last_sum - SW'(CAPACITY)) : AW'(last_sum);
  end

  // wrapping increments and decrement
  assign front_inc  = (front_r == AW'(CAPACITY - 1)) ? '0 : front_r + AW'(1);
  assign front_dec  = (front_r == '0) ? AW'(CAPACITY - 1) : front_r - AW'(1);
  assign rd_ptr_inc = (rd_ptr_r == AW'(CAPACITY - 1)) ? '0 : rd_ptr_r + AW'(1);

  // memory port selection
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = tail_addr;
    wr_data = item_d;
    rd_en   = 1'b0;
    rd_addr = rd_ptr_inc;
    if (ctrl.push_back) begin
      wr_en = 1'b1;
    end else if (ctrl.push_front) begin
      wr_en   = 1'b1;
      wr_addr = front_dec;
    end else if (ctrl.shift_wr) begin
      wr_en   = 1'b1;
      wr_addr = wr_ptr_r;
      wr_data = rd_data_r;
    end
    if (ctrl.pop_back) begin
      rd_en   = 1'b1;
      rd_addr = last_addr;
    end else if (ctrl.pop_front || ctrl.scan_start) begin
      rd_en   = 1'b1;
      rd_addr = front_r;
    end else if (ctrl.scan_step) begin
      rd_en = 1'b1;
    end
  end

  // ring store, registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  // front pointer and entry count
  always_comb begin
    front_nxt = front_r;
    count_nxt = count_r;
    if (ctrl.push_back) begin
      count_nxt = count_r + CW'(1);
    end
    if (ctrl.push_front) begin
      front_nxt = front_dec;
      count_nxt = count_r + CW'(1);
    end
    if (ctrl.pop_back || ctrl.erase_done) begin
      count_nxt = count_r - CW'(1);
    end
    if (ctrl.pop_front) begin
      front_nxt = front_inc;
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_r <= '0;
      count_r <= '0;
    end else begin
      front_r <= front_nxt;
      count_r <= count_nxt;
    end
  end

  // scan pointers and search key for erase
  always_comb begin
    rd_ptr_nxt = rd_ptr_r;
    wr_ptr_nxt = wr_ptr_r;
    idx_nxt    = idx_r;
    key_nxt    = key_r;
    if (ctrl.scan_start) begin
      rd_ptr_nxt = front_r;
      idx_nxt    = '0;
      key_nxt    = item_d;
    end else if (ctrl.scan_step) begin
      rd_ptr_nxt = rd_ptr_inc;
      wr_ptr_nxt = rd_ptr_r;
      idx_nxt    = idx_r + AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    rd_ptr_r <= rd_ptr_nxt;
    wr_ptr_r <= wr_ptr_nxt;
    idx_r    <= idx_nxt;
    key_r    <= key_nxt;
  end

  // result register
  always_ff @(posedge clk) begin
    if (ctrl.load_out) begin
      out_value_r  <= ctrl.out_sel_rd ? ITEM_W'(rd_data_r[IW-1:0]) : '0;
      out_status_r <= ctrl.out_status;
      out_count_r  <= COUNT_W'(count_nxt);
    end
  end

  // status toward the controller
  assign stat.empty = (count_r == '0);
  assign stat.full  = (count_r == CW'(CAPACITY));
  assign stat.match = (rd_data_r == key_r);
  assign stat.last  = (CW'(idx_r) == count_r - CW'(1));

  assign out_value  = out_value_r;
  assign out_status = out_status_r;
  assign out_count  = out_count_r;

  // count stays within capacity
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(CAPACITY))
    else $error("entry count above capacity");

  // compaction never reads the slot it writes
  a_shift_addr: assert property (@(posedge clk) disable iff (!rst_n)
    (ctrl.shift_wr && ctrl.scan_step) |-> (wr_ptr_r != rd_ptr_inc))
    else $error("compaction read and write collide");

endmodule

`default_nettype wire

// ----- rtl/dwe_controller.sv -----
// controller of the deque: command decode, erase scan sequencing and
// the result valid flag
// depends on dwe_pkg
`default_nettype none

module dwe_controller (
  input  wire                        clk,
  input  wire                        rst_n,
  input  wire                        in_tvalid,
  output logic                       in_tready,
  input  wire  [dwe_pkg::CMD_W-1:0]  in_cmd,
  output logic                       out_tvalid,
  input  wire                        out_tready,
  input  wire  dwe_pkg::dwe_stat_t   stat,
  output dwe_pkg::dwe_ctrl_t         ctrl
);
  import dwe_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_POP,
    S_SEARCH,
    S_SHIFT
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   accept;

  // take an item only when idle and the result register is free or leaving
  assign in_tready = (state_r == S_IDLE) && (!out_valid_r || out_tready);
  assign accept    = in_tvalid && in_tready;

  // next state and datapath commands
  always_comb begin
    state_nxt = state_r;
    ctrl      = '0;
    ctrl.out_status = ST_OK;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          unique case (cmd_t'(in_cmd))
            CMD_PUSH_BACK: begin
              ctrl.load_out = 1'b1;
              if (stat.full) begin
                ctrl.out_status = ST_FULL;
              end else begin
                ctrl.push_back = 1'b1;
              end
            end
            CMD_PUSH_FRONT: begin
              ctrl.load_out = 1'b1;
              if (stat.full) begin
                ctrl.out_status = ST_FULL;
              end else begin
                ctrl.push_front = 1'b1;
              end
            end
            CMD_POP_BACK: begin
              if (stat.empty) begin
                ctrl.load_out   = 1'b1;
                ctrl.out_status = ST_EMPTY;
              end else begin
                ctrl.pop_back = 1'b1;
                state_nxt     = S_POP;
              end
            end
            CMD_POP_FRONT: begin
              if (stat.empty) begin
                ctrl.load_out   = 1'b1;
                ctrl.out_status = ST_EMPTY;
              end else begin
                ctrl.pop_front = 1'b1;
                state_nxt      = S_POP;
              end
            end
            CMD_ERASE: begin
              if (stat.empty) begin
                ctrl.load_out   = 1'b1;
                ctrl.out_status = ST_NOT_FOUND;
              end else begin
                ctrl.scan_start = 1'b1;
                state_nxt       = S_SEARCH;
              end
            end
            default: begin
              ctrl.load_out = 1'b1;
            end
          endcase
        end
      end
      S_POP: begin
        ctrl.load_out   = 1'b1;
        ctrl.out_sel_rd = 1'b1;
        state_nxt       = S_IDLE;
      end
      S_SEARCH: begin
        if (stat.last) begin
          ctrl.load_out = 1'b1;
          state_nxt     = S_IDLE;
          if (stat.match) begin
            ctrl.erase_done = 1'b1;
          end else begin
            ctrl.out_status = ST_NOT_FOUND;
          end
        end else begin
          ctrl.scan_step = 1'b1;
          if (stat.match) begin
            state_nxt = S_SHIFT;
          end
        end
      end
      S_SHIFT: begin
        ctrl.shift_wr = 1'b1;
        if (stat.last) begin
          ctrl.erase_done = 1'b1;
          ctrl.load_out   = 1'b1;
          state_nxt       = S_IDLE;
        end else begin
          ctrl.scan_step = 1'b1;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // result valid: set on load, cleared when taken
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (ctrl.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_tvalid = out_valid_r;

  // a result is never loaded over one still waiting
  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.load_out |-> (!out_valid_r || out_tready))
    else $error("result register overwritten");

  // a pop on a non-empty store shows its result once S_POP has loaded the result register
  a_pop_result: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && !stat.empty &&
     (in_cmd == CMD_POP_BACK || in_cmd == CMD_POP_FRONT)) |=> ##1 out_valid_r)
    else $error("pop result missing");

endmodule

`default_nettype wire

// ----- rtl/deque_with_erase_by_value.sv -----
// Bounded double-ended queue of CAPACITY words of DATA_WIDTH bits, held in a
// ring store memory with one write and one registered read port. Commands on
// in_tuser push at the back or front, pop from the back or front, or erase the
// first entry from the front that equals in_tdata, closing the gap in order.
// Every command gives one result. A push, a refused push, or a pop or erase
// on an empty store loads its result in the cycle it is accepted; a pop first
// reads the store and loads the read word from S_POP. An erase walks every
// stored entry, found or not: the single read port reads one entry a cycle,
// comparing until the match and then copying each later entry one place
// forward. One command is in flight at a time; the next is taken once the
// controller is idle and the output register is empty or being read.
// depends on dwe_pkg, dwe_controller, dwe_datapath
`default_nettype none

module deque_with_erase_by_value #(
  parameter int CAPACITY   = dwe_pkg::DEF_CAPACITY,
  parameter int DATA_WIDTH = dwe_pkg::DEF_DATA_WIDTH
) (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_tvalid,
  output logic        in_tready,
  input  wire  [31:0] in_tdata,   // item_value[31:0]
  input  wire  [2:0]  in_tuser,   // cmd[2:0]
  output logic        out_tvalid,
  input  wire         out_tready,
  output logic [39:0] out_tdata,  // out_value[31:0], entry_count[36:32], zero[39:37]
  output logic [1:0]  out_tuser   // status[1:0]
);
  import dwe_pkg::*;

  dwe_ctrl_t            ctrl;
  dwe_stat_t            stat;
  logic [ITEM_W-1:0]    out_value;
  logic [STATUS_W-1:0]  out_status;
  logic [COUNT_W-1:0]   out_count;

  // command sequencing
  dwe_controller u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_cmd     (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .stat       (stat),
    .ctrl       (ctrl)
  );

  // storage and result register
  dwe_datapath #(
    .CAPACITY   (CAPACITY),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_value (in_tdata),
    .ctrl       (ctrl),
    .stat       (stat),
    .out_value  (out_value),
    .out_status (out_status),
    .out_count  (out_count)
  );

  // result packing
  assign out_tdata = {3'b000, out_count, out_value};
  assign out_tuser = out_status;

endmodule

`default_nettype wire
